/* hw/rtl/sle_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the serial line editor.
// Holds the beat structs, command kinds, result channels and character codes.
// No dependencies.
package sle_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [6:0] queue_free;
  } in_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic       last;
  } out_t;

  localparam logic [2:0] K_ECHO  = 3'd0;
  localparam logic [2:0] K_EOL   = 3'd1;
  localparam logic [2:0] K_INTR  = 3'd2;
  localparam logic [2:0] K_TAB   = 3'd3;
  localparam logic [2:0] K_ERASE = 3'd4;
  localparam logic [2:0] K_CHAR  = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rx_byte;
    logic [6:0] queue_free;
  } cmd_t;

  localparam logic       OP_RX    = 1'b0;

  localparam logic [1:0] CH_TERM  = 2'd0;
  localparam logic [1:0] CH_QUEUE = 2'd1;
  localparam logic [1:0] CH_INTR  = 2'd2;

  localparam logic [7:0] C_BEL    = 8'h07;
  localparam logic [7:0] C_BS     = 8'h08;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_LF     = 8'h0A;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_SP     = 8'h20;
  localparam logic [7:0] C_CARET  = 8'h5E;
  localparam logic [7:0] C_UPC    = 8'h43;
  localparam logic [7:0] C_DEL    = 8'h7F;
  localparam logic [7:0] INTR_RST = 8'h03;

endpackage

/* hw/rtl/serial_line_editor_unit.sv */
`timescale 1ns / 1ps
// Serial line editor top level: front end, command queue and back end.
// Depends on sle_pkg, sle_front, sle_cmd_fifo and sle_back.

// Beats are classified on arrival and wait in a two-entry command queue, so
// the input side keeps accepting while the back end works until the queue is
// full. Every beat is registered in the queue before the back end sees it.
// The back end runs one command at a time against a line memory with one
// write port, one read port and registered read data. A stored character,
// or a transmitter-ready beat with nothing to echo, is done as it is taken.
// A bell and an echo each emit one beat. A tab writes one padding space per
// step. An erase emits BS SP BS, and an interrupt emits an interrupt beat and
// then ^C CR LF. A line flush stores CR and LF and then reads and emits each
// flushed byte, since each byte needs a memory read before it is emitted.
module serial_line_editor_unit import sle_pkg::*; #(
  parameter int LINE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_head;

  sle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  sle_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  sle_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/sle_front.sv */
`timescale 1ns / 1ps
// Front end of the serial line editor: holds the interrupt character and
// classifies each input beat into a command. Depends on sle_pkg.
module sle_front import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       cmd_push,
  output cmd_t       cmd,
  input  logic       cmd_full
);

  logic [7:0] intr_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_char_r <= INTR_RST;
    end else if (cfg_wr_en) begin
      intr_char_r <= cfg_wr_data;
    end
  end

  assign in_ready = !cmd_full;
  assign cmd_push = in_valid && !cmd_full;

  always_comb begin
    cmd.rx_byte    = in_data.rx_byte;
    cmd.queue_free = in_data.queue_free;
    if (in_data.opcode != OP_RX) begin
      cmd.kind = K_ECHO;
    end else if (in_data.rx_byte == C_CR || in_data.rx_byte == C_LF) begin
      cmd.kind = K_EOL;
    end else if (in_data.rx_byte == intr_char_r) begin
      cmd.kind = K_INTR;
    end else if (in_data.rx_byte == C_TAB) begin
      cmd.kind = K_TAB;
    end else if (in_data.rx_byte == C_BS || in_data.rx_byte == C_DEL) begin
      cmd.kind = K_ERASE;
    end else begin
      cmd.kind = K_CHAR;
    end
  end

endmodule

/* hw/rtl/sle_cmd_fifo.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
// Depends on sle_pkg.
module sle_cmd_fifo import sle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = fifo_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* hw/rtl/sle_back.sv */
`timescale 1ns / 1ps
// Back end of the serial line editor: owns the line memory, length and echo
// position, and executes commands into result beats. Depends on sle_pkg.
module sle_back import sle_pkg::*; #(
  parameter int LINE_BYTES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam logic [LW-1:0] LIMIT = LW'(LINE_BYTES - 2);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ECHO_OUT = 3'd1;
  localparam logic [2:0] S_EOL_LF   = 3'd2;
  localparam logic [2:0] S_FL_RD    = 3'd3;
  localparam logic [2:0] S_FL_OUT   = 3'd4;
  localparam logic [2:0] S_SEQ      = 3'd5;
  localparam logic [2:0] S_TAB      = 3'd6;

  localparam logic [1:0] SQ_INTR  = 2'd0;
  localparam logic [1:0] SQ_ERASE = 2'd1;
  localparam logic [1:0] SQ_BELL  = 2'd2;

  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    wr_data;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] echo_r, echo_nxt;
  logic [6:0]    idx_r, idx_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [6:0]    qfree_r, qfree_nxt;
  logic [1:0]    seq_r, seq_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          out_free;
  logic          emit;
  out_t          emit_data;
  logic [LW-1:0] len_inc;
  logic [6:0]    len_inc7;
  logic [6:0]    idx_inc;
  logic [6:0]    eol_cnt;

  function automatic out_t seq_beat(input logic [1:0] sq, input logic [2:0] st);
    out_t b;
    b.channel   = CH_TERM;
    b.data_byte = C_BEL;
    b.last      = 1'b1;
    unique case (sq)
      SQ_INTR: begin
        b.last = (st == 3'd4);
        unique case (st)
          3'd0:    begin b.channel = CH_INTR; b.data_byte = 8'h00; end
          3'd1:    b.data_byte = C_CARET;
          3'd2:    b.data_byte = C_UPC;
          3'd3:    b.data_byte = C_CR;
          default: b.data_byte = C_LF;
        endcase
      end
      SQ_ERASE: begin
        b.last      = (st == 3'd2);
        b.data_byte = (st == 3'd1) ? C_SP : C_BS;
      end
      default: b.data_byte = C_BEL;
    endcase
    return b;
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign len_inc   = len_r + 1'b1;
  assign len_inc7  = 7'(len_inc);
  assign idx_inc   = idx_r + 7'd1;
  assign eol_cnt   = (qfree_r < len_inc7) ? qfree_r : len_inc7;
  assign rd_addr   = (state_r == S_FL_RD || state_r == S_FL_OUT) ? idx_r[AW-1:0]
                                                                 : echo_r[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[len_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    echo_nxt  = echo_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    qfree_nxt = qfree_r;
    seq_nxt   = seq_r;
    step_nxt  = step_r;
    cmd_pop   = 1'b0;
    wr_en     = 1'b0;
    wr_data   = C_SP;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          step_nxt = 3'd0;
          unique case (cmd.kind)
            K_ECHO: begin
              if (echo_r < len_r) begin
                state_nxt = S_ECHO_OUT;
              end
            end
            K_EOL: begin
              wr_en     = 1'b1;
              wr_data   = C_CR;
              len_nxt   = len_inc;
              qfree_nxt = cmd.queue_free;
              state_nxt = S_EOL_LF;
            end
            K_INTR: begin
              seq_nxt   = SQ_INTR;
              state_nxt = S_SEQ;
            end
            K_TAB: begin
              if (len_r < LIMIT) begin
                state_nxt = S_TAB;
              end
            end
            K_ERASE: begin
              seq_nxt   = (len_r != '0) ? SQ_ERASE : SQ_BELL;
              state_nxt = S_SEQ;
            end
            K_CHAR: begin
              if (len_r < LIMIT) begin
                wr_en   = 1'b1;
                wr_data = cmd.rx_byte;
                len_nxt = len_inc;
              end else begin
                seq_nxt   = SQ_BELL;
                state_nxt = S_SEQ;
              end
            end
            default: ;
          endcase
        end
      end
      S_ECHO_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{channel: CH_TERM, data_byte: rd_data_r, last: 1'b1};
          echo_nxt  = echo_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EOL_LF: begin
        wr_en   = 1'b1;
        wr_data = C_LF;
        cnt_nxt = eol_cnt;
        idx_nxt = 7'd0;
        if (eol_cnt == 7'd0) begin
          len_nxt   = '0;
          echo_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = len_inc;
          state_nxt = S_FL_RD;
        end
      end
      S_FL_RD: begin
        state_nxt = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{channel: CH_QUEUE, data_byte: rd_data_r, last: idx_inc == cnt_r};
          idx_nxt   = idx_inc;
          if (idx_inc == cnt_r) begin
            len_nxt   = '0;
            echo_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FL_RD;
          end
        end
      end
      S_SEQ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = seq_beat(seq_r, step_r);
          step_nxt  = step_r + 3'd1;
          if (emit_data.last) begin
            state_nxt = S_IDLE;
            if (seq_r == SQ_INTR) begin
              len_nxt  = '0;
              echo_nxt = '0;
            end else if (seq_r == SQ_ERASE) begin
              len_nxt  = len_r - 1'b1;
              echo_nxt = len_r - 1'b1;
            end
          end
        end
      end
      S_TAB: begin
        wr_en   = 1'b1;
        wr_data = C_SP;
        len_nxt = len_inc;
        if (!(len_inc < LIMIT && len_inc[2:0] != 3'd1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      echo_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      echo_r      <= echo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    qfree_r    <= qfree_nxt;
    seq_r      <= seq_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hw/rtl/sle_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the serial line editor and its bind to the top level.
// Depends on sle_pkg and serial_line_editor_unit.
module sle_checker import sle_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input in_t        in_data,
  input logic       out_valid,
  input logic       out_ready,
  input out_t       out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.channel == CH_TERM || out_data.channel == CH_QUEUE ||
                  out_data.channel == CH_INTR)
    else $error("result on an unknown channel");

  a_intr_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.channel == CH_INTR |-> out_data.data_byte == 8'h00 &&
                                                  !out_data.last)
    else $error("interrupt beat carries data or ends the item");

endmodule

bind serial_line_editor_unit sle_checker u_sle_checker (.*);
